// File: sv/bsfr_pkg.sv
// ----------------------------------------------------------------------------
// bsfr_pkg - shared types and constants of the byte stream find/replace block
// Register indexes, mode codes and the result bundle passed to the output
// buffer.
// ----------------------------------------------------------------------------
package bsfr_pkg;

  localparam int MAX_RESULTS = 8;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
  localparam int CFG_IDX_W   = 3;

  localparam logic [CFG_IDX_W-1:0] REG_REPLACE_MODE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_BYTES = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LEN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WORD_BYTES    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WORD_LEN      = 3'd4;

  localparam logic MODE_TOKEN  = 1'b0;
  localparam logic MODE_STRING = 1'b1;

  // Results caused by one input byte, slot 0 sent first.
  typedef struct packed {
    logic [MAX_RESULTS-1:0][7:0] data;
    logic [CNT_W-1:0]            count;
    logic                        last;
    logic                        bare;
  } res_t;

endpackage

// File: sv/bsfr_if.sv
// ----------------------------------------------------------------------------
// bsfr_if - stream and configuration channels
// Input byte channel, result channel and register write channel, each with
// valid/ready.
// ----------------------------------------------------------------------------
interface bsfr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, in_byte, in_last, input ready);
  modport sink (input valid, in_byte, in_last, output ready);
endinterface

interface bsfr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       string_end;
  logic       run_end;

  modport source (output valid, out_byte, byte_valid, string_end, run_end, input ready);
  modport sink (input valid, out_byte, byte_valid, string_end, run_end, output ready);
endinterface

interface bsfr_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [63:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: sv/bsfr_out_buf.sv
// ----------------------------------------------------------------------------
// bsfr_out_buf - result buffer
// Holds the results of one input byte and sends them one per cycle while
// the receiver is ready; a new set may load in the cycle the last one is taken.
// ----------------------------------------------------------------------------
module bsfr_out_buf (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  bsfr_pkg::res_t     res,
  output logic               room,
  bsfr_out_if.source         result
);

  logic [bsfr_pkg::MAX_RESULTS-1:0][7:0] data;
  logic [bsfr_pkg::CNT_W-1:0]            count;
  logic                                  last;
  logic                                  bare;
  logic                                  pop;

  assign pop  = result.valid && result.ready;
  assign room = (count == '0) || (count == bsfr_pkg::CNT_W'(1) && result.ready);

  assign result.valid      = (count != '0);
  assign result.out_byte   = data[0];
  assign result.byte_valid = !bare;
  assign result.run_end    = (count == bsfr_pkg::CNT_W'(1));
  assign result.string_end = last && (count == bsfr_pkg::CNT_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (load) begin
      count <= res.count;
    end else if (pop) begin
      count <= count - bsfr_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data <= res.data;
      last <= res.last;
      bare <= res.bare;
    end else if (pop) begin
      // advance to the next result
      for (int k = 0; k < bsfr_pkg::MAX_RESULTS - 1; k++) begin
        data[k] <= data[k+1];
      end
    end
  end

`ifndef SYNTHESIS
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= bsfr_pkg::CNT_W'(bsfr_pkg::MAX_RESULTS))
    else $error("result count above buffer depth");

  a_end_is_run_end: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.string_end |-> result.run_end)
    else $error("string end without run end");
`endif

endmodule

// File: sv/byte_stream_find_replace.sv
// ----------------------------------------------------------------------------
// byte_stream_find_replace - streaming find and replace over a byte string
// Token mode swaps set bytes for the word; string mode swaps whole pattern
// occurrences and flushes the held window at the end of the string.
// ----------------------------------------------------------------------------
// One input byte is taken per cycle while the result stream is not stalled
// and each byte yields at most one result. A byte that yields n results
// (a word of up to eight bytes, or the window flushed at the end of the
// string, capped at eight) holds the result buffer until all n have left;
// the next byte is taken in the cycle the last of them is accepted. A byte
// that yields nothing leaves the buffer free. The last byte of a string
// always yields at least one result, carrying string_end. Registers are
// written through cfg, which is always ready; writing replace_mode or
// pattern_len drops the bytes held in the window.
module byte_stream_find_replace #(
  parameter int MAX_PATTERN = 8,
  parameter int MAX_WORD    = 8
) (
  input  logic        clk,
  input  logic        rst,
  bsfr_in_if.sink     text,
  bsfr_out_if.source  result,
  bsfr_cfg_if.sink    cfg
);

  localparam int CW = $clog2(MAX_PATTERN + 1);

  logic        replace_mode;
  logic [63:0] pattern_bytes;
  logic [3:0]  pattern_len;
  logic [63:0] word_bytes;
  logic [3:0]  word_len;

  logic [MAX_PATTERN-1:0][7:0] window;
  logic [MAX_PATTERN-1:0][7:0] window_next;
  logic [CW-1:0]               wc;
  logic [CW-1:0]               wc_next;

  logic [MAX_PATTERN-1:0][7:0] wfull;
  logic [MAX_PATTERN-1:0][7:0] wshift;
  logic [CW-1:0]               plen;
  logic [CW-1:0]               wc0;
  logic [CW-1:0]               cnt1;
  logic [3:0]                  wlen;
  logic                        hit;
  logic                        same;
  logic                        full;
  logic                        room;
  logic                        load;
  bsfr_pkg::res_t              res;

  assign plen = (pattern_len > 4'(MAX_PATTERN)) ? CW'(MAX_PATTERN) : pattern_len[CW-1:0];
  assign wlen = (word_len > 4'(MAX_WORD)) ? 4'(MAX_WORD) : word_len;

  assign wc0  = (wc >= plen) ? plen - CW'(1) : wc;
  assign cnt1 = wc0 + CW'(1);
  assign full = (cnt1 == plen);

  always_comb begin
    hit  = 1'b0;
    same = 1'b1;
    for (int i = 0; i < MAX_PATTERN; i++) begin
      wfull[i] = (CW'(i) == wc0) ? text.in_byte : window[i];
      if (CW'(i) < plen && pattern_bytes[8*i +: 8] == text.in_byte) begin
        hit = 1'b1;
      end
    end
    for (int i = 0; i < MAX_PATTERN; i++) begin
      if (CW'(i) < plen && wfull[i] != pattern_bytes[8*i +: 8]) begin
        same = 1'b0;
      end
    end
    wshift = wfull;
    for (int i = 0; i < MAX_PATTERN - 1; i++) begin
      if (CW'(i) < plen - CW'(1)) begin
        wshift[i] = wfull[i+1];
      end
    end
  end

  always_comb begin
    res.data    = '0;
    res.count   = '0;
    res.last    = text.in_last;
    res.bare    = 1'b0;
    window_next = window;
    wc_next     = wc;
    if (replace_mode == bsfr_pkg::MODE_TOKEN || plen == '0) begin
      if (replace_mode == bsfr_pkg::MODE_TOKEN && hit) begin
        res.data  = word_bytes;
        res.count = bsfr_pkg::CNT_W'(wlen);
      end else begin
        res.data[0] = text.in_byte;
        res.count   = bsfr_pkg::CNT_W'(1);
      end
    end else begin
      window_next = wfull;
      for (int k = 0; k < bsfr_pkg::MAX_RESULTS; k++) begin
        if (k < MAX_PATTERN) begin
          res.data[k] = wfull[k];
        end
      end
      if (full && same) begin
        res.data  = word_bytes;
        res.count = bsfr_pkg::CNT_W'(wlen);
        wc_next   = '0;
      end else if (full) begin
        // oldest byte leaves; at string end the whole window goes out in order
        res.count   = text.in_last ? bsfr_pkg::CNT_W'(plen) : bsfr_pkg::CNT_W'(1);
        window_next = wshift;
        wc_next     = plen - CW'(1);
      end else begin
        res.count = text.in_last ? bsfr_pkg::CNT_W'(cnt1) : '0;
        wc_next   = cnt1;
      end
    end
    if (text.in_last) begin
      wc_next = '0;
      if (res.count == '0) begin
        res.bare    = 1'b1;
        res.count   = bsfr_pkg::CNT_W'(1);
        res.data[0] = 8'h00;
      end
    end
  end

  assign text.ready = room;
  assign load       = text.valid && room;
  assign cfg.ready  = 1'b1;

  bsfr_out_buf u_out_buf (
    .clk    (clk),
    .rst    (rst),
    .load   (load),
    .res    (res),
    .room   (room),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      replace_mode  <= bsfr_pkg::MODE_TOKEN;
      pattern_bytes <= '0;
      pattern_len   <= '0;
      word_bytes    <= '0;
      word_len      <= '0;
      wc            <= '0;
    end else begin
      if (load) begin
        wc <= wc_next;
      end
      if (cfg.valid && cfg.ready) begin
        unique case (cfg.index)
          bsfr_pkg::REG_REPLACE_MODE: begin
            replace_mode <= cfg.data[0];
            wc           <= '0;
          end
          bsfr_pkg::REG_PATTERN_BYTES: pattern_bytes <= cfg.data;
          bsfr_pkg::REG_PATTERN_LEN: begin
            pattern_len <= cfg.data[3:0];
            wc          <= '0;
          end
          bsfr_pkg::REG_WORD_BYTES: word_bytes <= cfg.data;
          bsfr_pkg::REG_WORD_LEN:   word_len   <= cfg.data[3:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      window <= window_next;
    end
  end

`ifndef SYNTHESIS
  a_token_no_window: assert property (@(posedge clk) disable iff (rst)
    replace_mode == bsfr_pkg::MODE_TOKEN |-> wc == '0)
    else $error("window holds bytes in token mode");

  a_last_gives_result: assert property (@(posedge clk) disable iff (rst)
    text.valid && text.ready && text.in_last |=> result.valid)
    else $error("string end request produced no result");

  a_cfg_drops_window: assert property (@(posedge clk) disable iff (rst)
    cfg.valid && cfg.ready &&
    (cfg.index == bsfr_pkg::REG_REPLACE_MODE || cfg.index == bsfr_pkg::REG_PATTERN_LEN)
    |=> wc == '0)
    else $error("window kept across mode or length write");
`endif

endmodule

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top - testbench of the byte stream find/replace block
// Drives byte strings through token and string mode under several register
// settings, predicts every result in the testbench, and checks the result
// stream field by field. Both sides idle at random.
// ----------------------------------------------------------------------------
module tb_top;

  localparam logic [bsfr_pkg::CFG_IDX_W-1:0] REG_SPARE_5 = 3'd5;
  localparam logic [bsfr_pkg::CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [bsfr_pkg::CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

  localparam logic [7:0] CH_T = "t";
  localparam logic [7:0] CH_S = "s";

  localparam int SETTLE_CYCLES = 8;
  localparam int LONG_HOLD     = 400;
  localparam int DRAIN_LIMIT   = 20000;

  localparam int MAX_PATTERN_TB = 8;
  localparam int MAX_WORD_TB    = 8;

  typedef struct packed {
    logic [7:0] b;
    logic       last;
  } text_item_t;

  typedef struct packed {
    logic [7:0] data;
    logic       has_byte;
    logic       str_end;
    logic       run_last;
  } outcome_t;

  logic clk;
  logic rst;

  bsfr_in_if  text_ch ();
  bsfr_out_if res_ch ();
  bsfr_cfg_if cfg_ch ();

  byte_stream_find_replace u_dut (
    .clk    (clk),
    .rst    (rst),
    .text   (text_ch),
    .result (res_ch),
    .cfg    (cfg_ch)
  );

  text_item_t pending_text[$];
  outcome_t   expected_out[$];
  int         mismatches;
  bit         text_fired;
  int         stall_req;

  // Register shadow and window of the predictor.
  logic        cur_mode;
  logic [63:0] cur_pattern;
  logic [3:0]  cur_pat_len;
  logic [63:0] cur_word;
  logic [3:0]  cur_word_len;
  logic [7:0]  win[MAX_PATTERN_TB];
  int          win_fill;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3000000;
    $display("tb_top: done, errors");
    $finish;
  end

  function automatic int eff_pat_len();
    return (cur_pat_len > MAX_PATTERN_TB) ? MAX_PATTERN_TB : int'(cur_pat_len);
  endfunction

  function automatic void apply_reg(logic [bsfr_pkg::CFG_IDX_W-1:0] idx, logic [63:0] value);
    case (idx)
      bsfr_pkg::REG_REPLACE_MODE: begin
        cur_mode = value[0];
        win_fill = 0;
      end
      bsfr_pkg::REG_PATTERN_BYTES: cur_pattern = value;
      bsfr_pkg::REG_PATTERN_LEN: begin
        cur_pat_len = value[3:0];
        win_fill    = 0;
      end
      bsfr_pkg::REG_WORD_BYTES: cur_word = value;
      bsfr_pkg::REG_WORD_LEN:   cur_word_len = value[3:0];
      default: ;
    endcase
  endfunction

  // Work out the results one accepted byte causes and queue them.
  function automatic void predict_rewrite(logic [7:0] b, logic last);
    logic [7:0] outq[$];
    int         plen;
    int         wlen;
    bit         hit;
    bit         same;
    int         n;
    outcome_t   o;
    plen = eff_pat_len();
    wlen = (cur_word_len > MAX_WORD_TB) ? MAX_WORD_TB : int'(cur_word_len);
    if (cur_mode == bsfr_pkg::MODE_TOKEN) begin
      hit = 1'b0;
      for (int i = 0; i < plen; i++)
        if (cur_pattern[8*i +: 8] == b) hit = 1'b1;
      if (hit) begin
        for (int i = 0; i < wlen; i++) outq.push_back(cur_word[8*i +: 8]);
      end else begin
        outq.push_back(b);
      end
    end else if (plen == 0) begin
      outq.push_back(b);
    end else begin
      if (win_fill >= plen) win_fill = plen - 1;
      win[win_fill] = b;
      win_fill++;
      if (win_fill == plen) begin
        same = 1'b1;
        for (int i = 0; i < plen; i++)
          if (win[i] != cur_pattern[8*i +: 8]) same = 1'b0;
        if (same) begin
          for (int i = 0; i < wlen; i++) outq.push_back(cur_word[8*i +: 8]);
          win_fill = 0;
        end else begin
          outq.push_back(win[0]);
          for (int i = 1; i < plen; i++) win[i-1] = win[i];
          win_fill = plen - 1;
        end
      end
    end
    if (last) begin
      // flush the held window unchanged
      for (int i = 0; i < win_fill; i++) outq.push_back(win[i]);
      win_fill = 0;
      if (outq.size() == 0) begin
        o.data     = 8'h00;
        o.has_byte = 1'b0;
        o.str_end  = 1'b1;
        o.run_last = 1'b1;
        expected_out.push_back(o);
        return;
      end
    end
    n = (outq.size() > bsfr_pkg::MAX_RESULTS) ? bsfr_pkg::MAX_RESULTS : outq.size();
    for (int k = 0; k < n; k++) begin
      o.data     = outq[k];
      o.has_byte = 1'b1;
      o.str_end  = last && (k == n - 1);
      o.run_last = (k == n - 1);
      expected_out.push_back(o);
    end
  endfunction

  // Monitor: predict on accepted requests, check accepted results.
  always @(posedge clk) begin : monitor
    outcome_t got;
    outcome_t want;
    text_fired = !rst && text_ch.valid && text_ch.ready;
    if (text_fired) begin
      predict_rewrite(text_ch.in_byte, text_ch.in_last);
      void'(pending_text.pop_front());
    end
    if (!rst && res_ch.valid && res_ch.ready) begin
      got.data     = res_ch.out_byte;
      got.has_byte = res_ch.byte_valid;
      got.str_end  = res_ch.string_end;
      got.run_last = res_ch.run_end;
      if (expected_out.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: byte %02h valid %0b string_end %0b run_end %0b",
                   got.data, got.has_byte, got.str_end, got.run_last);
      end else begin
        want = expected_out.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp byte %02h valid %0b end %0b run %0b, got %02h %0b %0b %0b",
                     want.data, want.has_byte, want.str_end, want.run_last,
                     got.data, got.has_byte, got.str_end, got.run_last);
        end
      end
    end
  end

  // Driver: bursts of requests with random gaps; hold a request until taken.
  int burst_left = 1;
  int gap_left   = 0;

  always @(negedge clk) begin
    if (rst) begin
      text_ch.valid <= 1'b0;
    end else if (text_ch.valid && !text_fired) begin
      // hold the request
    end else if (gap_left > 0) begin
      gap_left      <= gap_left - 1;
      text_ch.valid <= 1'b0;
    end else if (pending_text.size() == 0) begin
      text_ch.valid <= 1'b0;
    end else begin
      text_ch.valid   <= 1'b1;
      text_ch.in_byte <= pending_text[0].b;
      text_ch.in_last <= pending_text[0].last;
      if (burst_left <= 1) begin
        burst_left <= $urandom_range(1, 24);
        gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      end else begin
        burst_left <= burst_left - 1;
      end
    end
  end

  // Receiver: stall pattern changes every segment; long hold on request.
  int stall_seen = 0;
  int hold_left  = 0;
  int seg_left   = 0;
  int seg_mode   = 0;
  int rx_cycle   = 0;

  always @(negedge clk) begin : receiver
    logic rdy;
    rx_cycle <= rx_cycle + 1;
    if (stall_seen != stall_req) begin
      stall_seen <= stall_req;
      hold_left  <= LONG_HOLD;
      rdy = 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      rdy = 1'b0;
    end else begin
      if (seg_left == 0) begin
        seg_left <= $urandom_range(20, 80);
        seg_mode <= $urandom_range(0, 3);
      end else begin
        seg_left <= seg_left - 1;
      end
      case (seg_mode)
        0:       rdy = 1'b1;
        1:       rdy = ($urandom_range(0, 1) == 1);
        2:       rdy = ($urandom_range(0, 3) == 0);
        default: rdy = (rx_cycle % 4 != 3);
      endcase
    end
    res_ch.ready <= rdy;
  end

  task automatic write_reg(logic [bsfr_pkg::CFG_IDX_W-1:0] idx, logic [63:0] value);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    apply_reg(idx, value);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic send(logic [7:0] b, logic last);
    text_item_t it;
    it.b    = b;
    it.last = last;
    pending_text.push_back(it);
  endtask

  // Wait until every request is taken and every result has come back.
  task automatic settle();
    while (pending_text.size() != 0 || expected_out.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Build one string biased toward the current set bytes or pattern.
  task automatic queue_string(int len);
    logic [7:0] bytes_q[$];
    int         plen;
    int         run;
    int         r;
    logic [7:0] b;
    plen = eff_pat_len();
    while (bytes_q.size() < len) begin
      if (cur_mode == bsfr_pkg::MODE_STRING && plen > 0 && $urandom_range(0, 2) == 0) begin
        run = $urandom_range(0, 1) ? plen : $urandom_range(1, plen);
        for (int i = 0; i < run; i++) bytes_q.push_back(cur_pattern[8*i +: 8]);
      end else begin
        r = $urandom_range(0, 9);
        if (r < 4 && plen > 0) b = cur_pattern[8*$urandom_range(0, plen - 1) +: 8];
        else if (r < 6) b = r[0] ? CH_T : CH_S;
        else b = 8'($urandom);
        bytes_q.push_back(b);
      end
    end
    foreach (bytes_q[i]) send(bytes_q[i], i == bytes_q.size() - 1);
  endtask

  function automatic logic [3:0] pick_len(int max_len);
    case ($urandom_range(0, 5))
      0:       return 4'd0;
      1:       return 4'd1;
      2:       return 4'(max_len);
      3:       return 4'($urandom_range(max_len + 1, 15));
      default: return 4'($urandom_range(2, max_len - 1));
    endcase
  endfunction

  initial begin
    logic [63:0] pat;
    logic [7:0]  alpha[4];
    int          cnt;
    int          len;
    alpha = '{CH_T, CH_S, 8'h00, 8'hFF};
    mismatches       = 0;
    stall_req        = 0;
    text_fired       = 1'b0;
    text_ch.valid    = 1'b0;
    text_ch.in_byte  = 8'h00;
    text_ch.in_last  = 1'b0;
    res_ch.ready     = 1'b0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.index     = bsfr_pkg::REG_REPLACE_MODE;
    cfg_ch.data      = 64'h0;
    cur_mode         = bsfr_pkg::MODE_TOKEN;
    cur_pattern      = 64'h0;
    cur_pat_len      = 4'd0;
    cur_word         = 64'h0;
    cur_word_len     = 4'd0;
    win_fill         = 0;
    foreach (win[i]) win[i] = 8'h00;
    rst = 1'b1;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Reset settings: token mode with no set bytes passes everything.
    send(8'h00, 1'b0);
    send(8'hFF, 1'b1);
    settle();
    write_reg(REG_SPARE_5, {$urandom, $urandom});
    write_reg(REG_SPARE_6, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(REG_SPARE_7, 64'h0000_0000_0000_000F);

    // Token mode, set bytes t and s.
    write_reg(bsfr_pkg::REG_PATTERN_BYTES,
              {8'hA5, 8'h5A, 8'h80, 8'h01, 8'hFF, 8'h00, CH_S, CH_T});
    write_reg(bsfr_pkg::REG_PATTERN_LEN, 4'd2);
    write_reg(bsfr_pkg::REG_WORD_BYTES, 64'h5958);
    write_reg(bsfr_pkg::REG_WORD_LEN, 4'd2);
    send(CH_T, 1'b0);
    send("e", 1'b0);
    send(CH_S, 1'b0);
    send(CH_T, 1'b1);
    settle();

    // Oversized lengths clamp; zero byte matches.
    write_reg(bsfr_pkg::REG_PATTERN_LEN, 4'd15);
    write_reg(bsfr_pkg::REG_WORD_BYTES, {$urandom, $urandom});
    write_reg(bsfr_pkg::REG_WORD_LEN, 4'd12);
    send(8'h00, 1'b0);
    send(8'h41, 1'b1);
    settle();

    // Empty word deletes the last byte: bare end mark.
    write_reg(bsfr_pkg::REG_WORD_LEN, 4'd0);
    send(CH_T, 1'b1);
    settle();

    // String mode, pattern "ts", word "abc"; trailing byte flushed.
    write_reg(bsfr_pkg::REG_REPLACE_MODE, bsfr_pkg::MODE_STRING);
    write_reg(bsfr_pkg::REG_PATTERN_LEN, 4'd2);
    write_reg(bsfr_pkg::REG_WORD_BYTES, 64'h636261);
    write_reg(bsfr_pkg::REG_WORD_LEN, 4'd3);
    send("a", 1'b0);
    send(CH_T, 1'b0);
    send(CH_S, 1'b0);
    send(CH_T, 1'b1);
    settle();

    // Length rewrite mid-string drops the held byte.
    send(CH_T, 1'b0);
    settle();
    write_reg(bsfr_pkg::REG_PATTERN_LEN, 4'd2);
    send(CH_S, 1'b1);
    settle();

    // String mode with empty pattern passes bytes through.
    write_reg(bsfr_pkg::REG_PATTERN_LEN, 4'd0);
    send(CH_T, 1'b0);
    send(CH_S, 1'b1);
    settle();

    // Full-length pattern deleted as the whole string.
    write_reg(bsfr_pkg::REG_PATTERN_LEN, 4'd8);
    write_reg(bsfr_pkg::REG_WORD_LEN, 4'd0);
    for (int i = 0; i < 8; i++) send(cur_pattern[8*i +: 8], i == 7);
    settle();

    for (int ph = 0; ph < 14; ph++) begin
      if (ph == 0) begin
        pat = 64'hFFFF_FFFF_FFFF_FFFF;
      end else if (ph == 1) begin
        pat = 64'h0;
      end else if ($urandom_range(0, 2) == 0) begin
        for (int i = 0; i < 8; i++) pat[8*i +: 8] = alpha[$urandom_range(0, 3)];
      end else begin
        pat = {$urandom, $urandom};
      end
      write_reg(bsfr_pkg::REG_REPLACE_MODE,
                (ph < 2) ? logic'(ph == 0) : logic'($urandom_range(0, 1)));
      write_reg(bsfr_pkg::REG_PATTERN_BYTES, pat);
      write_reg(bsfr_pkg::REG_PATTERN_LEN, (ph < 2) ? 4'd8 : pick_len(8));
      write_reg(bsfr_pkg::REG_WORD_BYTES,
                (ph == 3) ? 64'hFFFF_FFFF_FFFF_FFFF : {$urandom, $urandom});
      write_reg(bsfr_pkg::REG_WORD_LEN, (ph < 2) ? 4'd8 : pick_len(8));
      if ($urandom_range(0, 3) == 0) write_reg(REG_SPARE_5, {$urandom, $urandom});
      if (ph == 2) stall_req++;
      cnt = 0;
      while (cnt < 27) begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
        queue_string(len);
        cnt += len;
      end
      // leave a string open now and then across the register rewrite
      if ($urandom_range(0, 3) == 0) send(8'($urandom), 1'b0);
      settle();
    end

    begin : drain
      int waited;
      waited = 0;
      while ((pending_text.size() != 0 || expected_out.size() != 0) && waited < DRAIN_LIMIT) begin
        @(posedge clk);
        waited++;
      end
      repeat (20) @(posedge clk);
      if (pending_text.size() != 0 || expected_out.size() != 0) begin
        mismatches++;
        $display("left over: %0d requests, %0d results", pending_text.size(),
                 expected_out.size());
      end
    end

    if (mismatches == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
